### design/quadrature_step_decoder_unit_macros.svh
// Assertion macros for the quadrature step decoder
`ifndef QUADRATURE_STEP_DECODER_UNIT_MACROS_SVH
`define QUADRATURE_STEP_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define QSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qsd check failed");

// next-cycle implication, checked while out of reset
`define QSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qsd check failed");

// next-cycle implication, also checked through reset
`define QSD_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qsd check failed");

`endif

### design/qsd_pkg.sv
package qsd_pkg;

  localparam int QSD_QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_LIMIT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_TIMEOUT = 1'b1;

  localparam logic [6:0]  STEP_LIMIT_RESET    = 7'd0;
  localparam logic [15:0] CLEAR_TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] IDLE_MAX            = 16'hFFFF;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic signed [1:0] DIR_NONE = 2'b00;
  localparam logic signed [1:0] DIR_CW   = 2'b01;
  localparam logic signed [1:0] DIR_CCW  = 2'b11;

  localparam logic [1:0] SENSE_NONE = 2'd0;
  localparam logic [1:0] SENSE_CW   = 2'd1;
  localparam logic [1:0] SENSE_CCW  = 2'd2;

  localparam logic [3:0] TR_CW_0  = 4'b1101;
  localparam logic [3:0] TR_CW_1  = 4'b0100;
  localparam logic [3:0] TR_CW_2  = 4'b0010;
  localparam logic [3:0] TR_CW_3  = 4'b1011;
  localparam logic [3:0] TR_CCW_0 = 4'b1110;
  localparam logic [3:0] TR_CCW_1 = 4'b0111;
  localparam logic [3:0] TR_CCW_2 = 4'b0001;
  localparam logic [3:0] TR_CCW_3 = 4'b1000;

  typedef struct packed {
    logic kind;
    logic pin_a;
    logic pin_b;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] direction;
    logic              moved;
  } out_item_t;

  typedef struct packed {
    logic       is_tick;
    logic [1:0] code;
  } q_entry_t;

  typedef struct packed {
    logic [6:0]  step_limit;
    logic [15:0] clear_timeout_ms;
  } cfg_t;

  function automatic logic [1:0] trans_sense(input logic [3:0] t);
    logic [1:0] sense;
    case (t)
      TR_CW_0, TR_CW_1, TR_CW_2, TR_CW_3:     sense = SENSE_CW;
      TR_CCW_0, TR_CCW_1, TR_CCW_2, TR_CCW_3: sense = SENSE_CCW;
      default:                                sense = SENSE_NONE;
    endcase
    return sense;
  endfunction

endpackage

### design/quadrature_step_decoder_unit.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_data   (kind, pin_a, pin_b)
// out       out_valid / out_ready  out_data  (direction, moved)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a sample's result passes
// a queue slot, then the output register, before it is offered; a tick leaves
// no result. The rate is set by the state update in the back end.
// Synchronous reset clears the queue, decoder state and output valid; the
// configuration returns to step limit 0 and timeout 500 ms.
// A stalled output holds its item; ticks still drain the queue meanwhile.
module quadrature_step_decoder_unit #(
  parameter int QUEUE_DEPTH = qsd_pkg::QSD_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qsd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qsd_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [qsd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import qsd_pkg::*;

  cfg_t     cfg;
  logic     push_valid;
  logic     push_ready;
  q_entry_t push_entry;
  logic     pop_valid;
  logic     pop_ready;
  q_entry_t pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_limit       <= STEP_LIMIT_RESET;
      cfg.clear_timeout_ms <= CLEAR_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_LIMIT:    cfg.step_limit       <= cfg_data[6:0];
        REG_CLEAR_TIMEOUT: cfg.clear_timeout_ms <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  qsd_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  qsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  qsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/qsd_front.sv
module qsd_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  qsd_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output qsd_pkg::q_entry_t push_entry
);
  import qsd_pkg::*;

  always_comb begin
    in_ready           = push_ready;
    push_valid         = in_valid;
    push_entry.is_tick = (in_data.kind == KIND_TICK);
    // pins mean nothing on a tick
    push_entry.code    = push_entry.is_tick ? 2'b00 : {in_data.pin_a, in_data.pin_b};
  end

endmodule

### design/qsd_queue.sv
module qsd_queue #(
  parameter int DEPTH = qsd_pkg::QSD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  qsd_pkg::q_entry_t push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output qsd_pkg::q_entry_t pop_entry
);
  import qsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               push;
  logic               pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/qsd_back.sv
module qsd_back (
  input  logic               clk,
  input  logic               rst,
  input  qsd_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  qsd_pkg::q_entry_t  pop_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output qsd_pkg::out_item_t out_data
);
  import qsd_pkg::*;

  logic [1:0]        prev_code;
  logic signed [7:0] step_count;
  logic signed [1:0] held_direction;
  logic [15:0]       idle_ms;

  logic [1:0]        prev_code_next;
  logic signed [7:0] step_count_next;
  logic signed [1:0] held_direction_next;
  logic [15:0]       idle_ms_next;

  logic              timed_out;
  logic [1:0]        prev_eff;
  logic signed [7:0] count_eff;
  logic signed [1:0] dir_eff;
  logic signed [7:0] lim;
  logic signed [7:0] neg_lim;
  logic signed [7:0] base;
  logic [1:0]        sense;
  logic              take;
  logic              sample;

  assign pop_ready = pop_entry.is_tick || !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;
  assign sample    = take && !pop_entry.is_tick;

  always_comb begin
    timed_out           = (idle_ms > cfg.clear_timeout_ms);
    prev_eff            = timed_out ? 2'b00 : prev_code;
    count_eff           = timed_out ? 8'sd0 : step_count;
    dir_eff             = timed_out ? DIR_NONE : held_direction;
    lim                 = $signed({1'b0, cfg.step_limit});
    neg_lim             = -lim;
    sense               = trans_sense({prev_eff, pop_entry.code});
    base                = count_eff;
    prev_code_next      = pop_entry.code;
    step_count_next     = count_eff;
    held_direction_next = dir_eff;
    idle_ms_next        = 16'd0;

    case (sense)
      SENSE_CW: begin
        base = (count_eff < 8'sd0) ? 8'sd0 : count_eff;
        if (base >= lim) begin
          step_count_next     = 8'sd0;
          held_direction_next = DIR_CW;
        end else begin
          step_count_next = base + 8'sd1;
        end
      end
      SENSE_CCW: begin
        base = (count_eff > 8'sd0) ? 8'sd0 : count_eff;
        if (base <= neg_lim) begin
          step_count_next     = 8'sd0;
          held_direction_next = DIR_CCW;
        end else begin
          step_count_next = base - 8'sd1;
        end
      end
      default: begin
        held_direction_next = DIR_NONE;
      end
    endcase

    // tick: advance the idle timer, saturating
    if (pop_entry.is_tick) begin
      prev_code_next      = prev_code;
      step_count_next     = step_count;
      held_direction_next = held_direction;
      idle_ms_next        = (idle_ms == IDLE_MAX) ? idle_ms : idle_ms + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_code      <= 2'b00;
      step_count     <= 8'sd0;
      held_direction <= DIR_NONE;
      idle_ms        <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        prev_code      <= prev_code_next;
        step_count     <= step_count_next;
        held_direction <= held_direction_next;
        idle_ms        <= idle_ms_next;
      end
      if (sample) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample) begin
      out_data.direction <= held_direction_next;
      out_data.moved     <= (held_direction_next != DIR_NONE);
    end
  end

endmodule

### design/qsd_checker.sv
`include "quadrature_step_decoder_unit_macros.svh"

module qsd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input qsd_pkg::out_item_t              out_data,
  input logic                            cfg_ready
);
  import qsd_pkg::*;

  `QSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `QSD_ASSERT_NOW(a_moved_matches, out_valid, out_data.moved == (out_data.direction != DIR_NONE))
  `QSD_ASSERT_NOW(a_direction_legal, out_valid, out_data.direction != 2'b10)
  `QSD_ASSERT_ALWAYS_NEXT(a_reset_empties, rst, !out_valid && cfg_ready)

endmodule

bind quadrature_step_decoder_unit qsd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_HOLD      = 120;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  quadrature_step_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  in_item_t  pending_items[$];
  out_item_t expected_dirs[$];

  logic [6:0]        limit_reg   = STEP_LIMIT_RESET;
  logic [15:0]       timeout_reg = CLEAR_TIMEOUT_RESET;
  logic [1:0]        last_code   = '0;
  logic signed [7:0] step_cnt    = '0;
  logic signed [1:0] held_dir    = DIR_NONE;
  logic [15:0]       idle_cnt    = '0;

  int         mismatches   = 0;
  int         in_gap       = 0;
  int         out_gap      = 0;
  int         results_seen = 0;
  int         quiet_cycles = 0;
  bit         steady       = 1'b0;
  logic [1:0] walk_pos     = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // position of a pin code on the clockwise cycle 00, 10, 11, 01
  function automatic logic [1:0] ring_pos(input logic [1:0] c);
    case (c)
      2'b00:   ring_pos = 2'd0;
      2'b10:   ring_pos = 2'd1;
      2'b11:   ring_pos = 2'd2;
      default: ring_pos = 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] ring_code(input logic [1:0] p);
    case (p)
      2'd0:    ring_code = 2'b00;
      2'd1:    ring_code = 2'b10;
      2'd2:    ring_code = 2'b11;
      default: ring_code = 2'b01;
    endcase
  endfunction

  function automatic logic [1:0] step_sense(input logic [1:0] from, input logic [1:0] to);
    logic [1:0] d;
    d = ring_pos(to) - ring_pos(from);
    if (d == 2'd1)
      return SENSE_CW;
    if (d == 2'd3)
      return SENSE_CCW;
    return SENSE_NONE;
  endfunction

  function automatic int idle_len(input bit none);
    int r;
    r = $urandom_range(0, 99);
    if (none || r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic track_item(input in_item_t it);
    logic [1:0]        code;
    logic signed [7:0] lim;
    out_item_t         res;
    lim = $signed({1'b0, limit_reg});
    if (it.kind == KIND_TICK) begin
      if (idle_cnt != IDLE_MAX)
        idle_cnt = idle_cnt + 16'd1;
    end else begin
      if (idle_cnt > timeout_reg) begin
        last_code = '0;
        step_cnt  = '0;
        held_dir  = DIR_NONE;
      end
      code = {it.pin_a, it.pin_b};
      case (step_sense(last_code, code))
        SENSE_CW: begin
          if (step_cnt < 0)
            step_cnt = '0;
          if (step_cnt >= lim) begin
            step_cnt = '0;
            held_dir = DIR_CW;
          end else begin
            step_cnt = step_cnt + 8'sd1;
          end
        end
        SENSE_CCW: begin
          if (step_cnt > 0)
            step_cnt = '0;
          if (step_cnt <= -lim) begin
            step_cnt = '0;
            held_dir = DIR_CCW;
          end else begin
            step_cnt = step_cnt - 8'sd1;
          end
        end
        default: held_dir = DIR_NONE;
      endcase
      last_code = code;
      idle_cnt  = '0;
      res.direction = held_dir;
      res.moved     = (held_dir != DIR_NONE);
      expected_dirs.push_back(res);
    end
  endtask

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s", what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        track_item(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap = idle_len(steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_dirs.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: direction %0d moved %0b",
                               results_seen, out_data.direction, out_data.moved));
        end else begin
          want = expected_dirs.pop_front();
          if (out_data.direction !== want.direction || out_data.moved !== want.moved)
            flag_error($sformatf({"result %0d: expected direction %0d moved %0b,",
                                  " got direction %0d moved %0b"},
                                 results_seen, want.direction, want.moved,
                                 out_data.direction, out_data.moved));
        end
        // hold off long enough for the block to back up into its input
        if (results_seen == 60 || results_seen == 400)
          out_gap = LONG_HOLD;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = idle_len(steady);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_STEP_LIMIT)
      limit_reg = val[6:0];
    else
      timeout_reg = val;
  endtask

  task automatic set_config(input int lim, input int tmo);
    write_reg(REG_STEP_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_CLEAR_TIMEOUT, CFG_DATA_W'(tmo));
    @(negedge clk);
  endtask

  task automatic push_sample(input logic [1:0] code);
    in_item_t it;
    it.kind  = KIND_SAMPLE;
    it.pin_a = code[1];
    it.pin_b = code[0];
    pending_items.push_back(it);
    walk_pos = ring_pos(code);
  endtask

  task automatic push_tick();
    in_item_t   it;
    logic [1:0] stray;
    stray    = 2'($urandom_range(0, 3));
    it.kind  = KIND_TICK;
    it.pin_a = stray[1];
    it.pin_b = stray[0];
    pending_items.push_back(it);
  endtask

  task automatic turn(input bit ccw, input int steps);
    repeat (steps)
      push_sample(ring_code(ccw ? walk_pos - 2'd1 : walk_pos + 2'd1));
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_items.size() != 0 || in_valid || expected_dirs.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    int         left;
    int         r;
    int         n;
    logic [1:0] code;
    left = count;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(1, limit_reg + 6);
        turn(1'($urandom_range(0, 1)), n);
        left -= n;
        if ($urandom_range(0, 3) == 0) begin
          push_tick();
          left--;
        end
      end else if (r < 85) begin
        code = 2'($urandom_range(0, 3));
        push_sample(code);
        left--;
      end else begin
        if (timeout_reg < 40 && $urandom_range(0, 1) == 1)
          n = timeout_reg + 1;
        else
          n = $urandom_range(1, 4);
        repeat (n) push_tick();
        left -= n;
      end
    end
  endtask

  initial begin
    int walk_codes[17];
    walk_codes = '{0, 0, 1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every transition at least once, under the reset settings
    push_tick();
    foreach (walk_codes[i]) begin
      push_sample(walk_codes[i][1:0]);
      if (i == 8)
        push_tick();
    end
    push_tick();
    wait_drained();

    // lower the limit below a running count, then reach minus the limit
    set_config(10, 65535);
    turn(1'b0, 8);
    wait_drained();
    set_config(2, 65535);
    turn(1'b0, 1);
    turn(1'b1, 3);
    wait_drained();

    // zero timeout: a single tick clears before the next sample
    set_config(0, 0);
    turn(1'b0, 1);
    push_tick();
    turn(1'b0, 1);
    turn(1'b0, 1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_config(0, 0);
        1:       set_config(3, 2);
        2:       set_config(127, 65535);
        3:       set_config($urandom_range(0, 8), $urandom_range(0, 20));
        4:       set_config($urandom_range(0, 127), $urandom_range(0, 65535));
        default: set_config(1, 500);
      endcase
      steady = (p == 2 || p == 4);
      random_phase(150);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_dirs.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
